### hdl/frame_slot_ring_with_checkout_core_defines.svh
// Assertion macros shared by the frame slot ring RTL.
`ifndef FRAME_SLOT_RING_WITH_CHECKOUT_CORE_DEFINES_SVH
`define FRAME_SLOT_RING_WITH_CHECKOUT_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk and disabled in reset.
`define FSR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk and disabled in reset.
`define FSR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/fsr_pkg.sv
// Types and constants shared by the frame slot ring modules.
`default_nettype none
package fsr_pkg;

  localparam int SLOT_W  = 6;
  localparam int CNT_W   = 7;
  localparam int STAMP_W = 64;
  localparam int DIM_W   = 14;
  localparam int BYTES_W = 27;
  localparam int IN_W    = 80;
  localparam int OUT_W   = 112;
  localparam int CFG_IDX_W = 2;

  localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [STAMP_W-1:0] stamp_t;
  typedef logic [DIM_W-1:0]   dim_t;
  typedef logic [BYTES_W-1:0] bytes_t;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_GET     = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_ALL_TAKEN = 3'd1,
    ST_COPY_FAIL = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_NONE_FREE = 3'd4,
    ST_BAD_SLOT  = 3'd5
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SLOTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

  typedef struct packed {
    logic  wr_en;
    slot_t wr_addr;
    logic  rd_en;
    slot_t rd_addr;
  } stamp_req_t;

endpackage
`default_nettype wire

### hdl/fsr_stamp_mem.sv
// Timestamp store: one write port and one registered read port.
`default_nettype none
module fsr_stamp_mem #(
  parameter int DEPTH = 8
) (
  input  wire logic               clk,
  input  wire fsr_pkg::stamp_req_t req,
  input  wire fsr_pkg::stamp_t    wr_data,
  output fsr_pkg::stamp_t         rd_data
);
  import fsr_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  stamp_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[AW-1:0]] <= wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr[AW-1:0]];
    end
  end

endmodule
`default_nettype wire

### hdl/fsr_size.sv
// NV12 frame size unit: registered width times height, then three halves, saturated.
`default_nettype none
module fsr_size (
  input  wire logic          clk,
  input  wire fsr_pkg::dim_t frame_width,
  input  wire fsr_pkg::dim_t frame_height,
  output fsr_pkg::bytes_t    frame_bytes
);
  import fsr_pkg::*;

  logic [2*DIM_W-1:0] area;
  logic [2*DIM_W:0]   sum;

  assign sum = {1'b0, area} + {2'b00, area[2*DIM_W-1:1]};

  always_ff @(posedge clk) begin
    area <= frame_width * frame_height;
    if (sum > {2'b00, BYTES_MAX}) begin
      frame_bytes <= BYTES_MAX;
    end else begin
      frame_bytes <= sum[BYTES_W-1:0];
    end
  end

endmodule
`default_nettype wire

### hdl/frame_slot_ring_with_checkout_core.sv
// Frame slot ring with checkout: top level with command sequencer and slot state.
//
// Input beats on s_* carry one command (write, get, release or no-op); each
// command gives exactly one result beat on m_*. Configuration registers
// (active slots, frame width, frame height) are written on cfg_*; the user must
// write them only while the block is idle, which the block does not enforce.
// cfg_ready is always high. A command is accepted in the idle state; write and get
// then examine one slot per cycle in the scan state (1 to n slots, n being the
// clamped active slot count), a successful get reads its stamp in the fetch state,
// and the output state loads m_tdata. Release, no-op and an empty get skip both.
// The next command is accepted as soon as the result sits in the output
// register, even while the receiver has not taken it yet. If the receiver
// stalls with a result still held, the next result waits in the sequencer
// and no further command is accepted until it moves.
// Reset clears all slot marks, both pointers and the frame count, and loads
// the configuration defaults; slot timestamps stay undefined until written.
`default_nettype none
`include "frame_slot_ring_with_checkout_core_defines.svh"
module frame_slot_ring_with_checkout_core #(
  parameter int SLOTS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // cmd[1:0], stamp_in[65:2], copy_ok[66], release_slot[72:67], zero [79:73]
  input  wire logic [fsr_pkg::IN_W-1:0]      s_tdata,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // status[2:0], slot_out[8:3], stamp_out[72:9], frame_bytes[99:73],
  // ready_frames[106:100], zero [111:107]
  output logic [fsr_pkg::OUT_W-1:0]          m_tdata,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [fsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fsr_pkg::DIM_W-1:0]     cfg_data
);
  import fsr_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [CNT_W-1:0] SLOTS_N = CNT_W'(SLOTS);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_FETCH = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t state;

  logic [CNT_W-1:0] active_slots;
  dim_t             frame_width;
  dim_t             frame_height;
  bytes_t           frame_bytes;

  logic [SLOTS-1:0] written;
  logic [SLOTS-1:0] taken;
  logic [IW-1:0]    write_ptr;
  logic [IW-1:0]    read_ptr;
  logic [CNT_W-1:0] ready_count;

  cmd_t             cmd_q;
  stamp_t           stamp_q;
  logic             copy_q;
  logic [CNT_W-1:0] n_q;
  logic [CNT_W-1:0] k;
  logic [IW-1:0]    idx;

  status_t          res_status;
  slot_t            res_slot;
  stamp_t           res_stamp;
  logic             res_get;

  cmd_t             in_cmd;
  stamp_t           in_stamp;
  logic             in_copy;
  slot_t            in_rel;
  logic [CNT_W-1:0] n_now;
  logic [IW-1:0]    wp_norm;
  logic [IW-1:0]    rp_norm;
  logic [IW-1:0]    idx_next;
  logic             scan_last;
  logic             wr_hit;
  logic             get_hit;

  stamp_req_t       stamp_req;
  stamp_t           stamp_rd;

  assign in_cmd   = cmd_t'(s_tdata[1:0]);
  assign in_stamp = s_tdata[65:2];
  assign in_copy  = s_tdata[66];
  assign in_rel   = s_tdata[72:67];

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    if (active_slots == '0) begin
      n_now = CNT_W'(1);
    end else if (active_slots > SLOTS_N) begin
      n_now = SLOTS_N;
    end else begin
      n_now = active_slots;
    end
  end

  assign wp_norm   = (CNT_W'(write_ptr) >= n_now) ? '0 : write_ptr;
  assign rp_norm   = (CNT_W'(read_ptr) >= n_now) ? '0 : read_ptr;
  assign idx_next  = (CNT_W'(idx) + CNT_W'(1) >= n_q) ? '0 : idx + IW'(1);
  assign scan_last = (k + CNT_W'(1) >= n_q);
  assign wr_hit    = !taken[idx];
  assign get_hit   = written[idx] && !taken[idx];

  always_comb begin
    stamp_req.wr_en   = (state == S_SCAN) && (cmd_q == CMD_WRITE) && wr_hit && copy_q;
    stamp_req.wr_addr = SLOT_W'(idx);
    stamp_req.rd_en   = (state == S_SCAN) && (cmd_q == CMD_GET) && get_hit;
    stamp_req.rd_addr = SLOT_W'(idx);
  end

  fsr_stamp_mem #(
    .DEPTH (SLOTS)
  ) u_stamp_mem (
    .clk     (clk),
    .req     (stamp_req),
    .wr_data (stamp_q),
    .rd_data (stamp_rd)
  );

  fsr_size u_size (
    .clk          (clk),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .frame_bytes  (frame_bytes)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      active_slots <= CNT_W'(8);
      frame_width  <= DIM_W'(1920);
      frame_height <= DIM_W'(1080);
      written      <= '0;
      taken        <= '0;
      write_ptr    <= '0;
      read_ptr     <= '0;
      ready_count  <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_ACTIVE_SLOTS: active_slots <= cfg_data[CNT_W-1:0];
          CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
          CFG_FRAME_HEIGHT: frame_height <= cfg_data;
          default: ;
        endcase
      end

      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            n_q       <= n_now;
            cmd_q     <= in_cmd;
            stamp_q   <= in_stamp;
            copy_q    <= in_copy;
            k         <= '0;
            write_ptr <= wp_norm;
            read_ptr  <= rp_norm;
            res_stamp <= '0;
            res_get   <= 1'b0;
            unique case (in_cmd)
              CMD_WRITE: begin
                res_status <= ST_DONE;
                res_slot   <= '0;
                idx        <= wp_norm;
                state      <= S_SCAN;
              end
              CMD_GET: begin
                res_slot <= '0;
                if (ready_count == '0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_OUT;
                end else begin
                  res_status <= ST_DONE;
                  idx        <= rp_norm;
                  state      <= S_SCAN;
                end
              end
              CMD_RELEASE: begin
                if ({1'b0, in_rel} >= n_now) begin
                  res_status <= ST_BAD_SLOT;
                  res_slot   <= '0;
                end else begin
                  res_status            <= ST_DONE;
                  taken[in_rel[IW-1:0]] <= 1'b0;
                  res_slot              <= in_rel;
                end
                state <= S_OUT;
              end
              default: begin
                res_status <= ST_DONE;
                res_slot   <= '0;
                state      <= S_OUT;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (cmd_q == CMD_WRITE) begin
            if (wr_hit) begin
              if (!copy_q) begin
                res_status <= ST_COPY_FAIL;
              end else begin
                written[idx] <= 1'b1;
                if (!written[idx] && ready_count < n_q) begin
                  ready_count <= ready_count + CNT_W'(1);
                end
                write_ptr <= idx_next;
                res_slot  <= SLOT_W'(idx);
              end
              state <= S_OUT;
            end else if (scan_last) begin
              res_status <= ST_ALL_TAKEN;
              state      <= S_OUT;
            end else begin
              idx <= idx_next;
              k   <= k + CNT_W'(1);
            end
          end else begin
            read_ptr <= idx_next;
            if (get_hit) begin
              taken[idx]   <= 1'b1;
              written[idx] <= 1'b0;
              ready_count  <= ready_count - CNT_W'(1);
              res_slot     <= SLOT_W'(idx);
              res_get      <= 1'b1;
              state        <= S_FETCH;
            end else if (scan_last) begin
              res_status <= ST_NONE_FREE;
              state      <= S_OUT;
            end else begin
              idx <= idx_next;
              k   <= k + CNT_W'(1);
            end
          end
        end
        S_FETCH: begin
          res_stamp <= stamp_rd;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {5'b0, ready_count, (res_get ? frame_bytes : '0),
                         res_stamp, res_slot, res_status};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `FSR_ASSERT_IMP(a_count_max, 1'b1, ready_count <= SLOTS_N,
                  "frame count above ring size")
  `FSR_ASSERT_IMP(a_scan_bound, state == S_SCAN, k < n_q,
                  "scan ran past the ring")
  `FSR_ASSERT_IMP(a_written_free, 1'b1, (written & taken) == '0,
                  "slot both written and checked out")
  `FSR_ASSERT_NXT(a_one_cmd, s_tvalid && s_tready, !s_tready,
                  "second beat accepted while a command is in progress")

endmodule
`default_nettype wire

### bench/tb_frame_slot_ring_with_checkout_core.sv
// Self-checking bench for the frame slot ring: predicts every result beat and compares it.
import fsr_pkg::*;

typedef struct {
  cmd_t   cmd;
  stamp_t stamp;
  logic   copy_ok;
  slot_t  release_slot;
} ring_cmd_t;

typedef struct {
  status_t          status;
  slot_t            slot;
  stamp_t           stamp;
  bytes_t           bytes;
  logic [CNT_W-1:0] count;
} ring_result_t;

class slot_ring_scoreboard #(int RING_SLOTS = 8);
  logic [CNT_W-1:0] active_slots;
  dim_t             frame_width;
  dim_t             frame_height;
  bit               slot_written [RING_SLOTS];
  bit               slot_taken [RING_SLOTS];
  stamp_t           slot_stamp [RING_SLOTS];
  int unsigned      write_ptr;
  int unsigned      read_ptr;
  int unsigned      ready_count;
  ring_result_t     pending_results [$];
  int               error_count;

  function new();
    active_slots = 7'd8;
    frame_width  = 14'd1920;
    frame_height = 14'd1080;
    for (int i = 0; i < RING_SLOTS; i++) begin
      slot_written[i] = 1'b0;
      slot_taken[i]   = 1'b0;
      slot_stamp[i]   = '0;
    end
    write_ptr   = 0;
    read_ptr    = 0;
    ready_count = 0;
    error_count = 0;
  endfunction

  function int unsigned ring_size();
    if (active_slots == 0) return 1;
    if (active_slots > RING_SLOTS) return RING_SLOTS;
    return active_slots;
  endfunction

  function int unsigned next_slot(int unsigned i, int unsigned n);
    return (i + 1 >= n) ? 0 : i + 1;
  endfunction

  function void note_config(logic [CFG_IDX_W-1:0] index, dim_t data);
    case (index)
      CFG_ACTIVE_SLOTS: active_slots = data[CNT_W-1:0];
      CFG_FRAME_WIDTH:  frame_width  = data;
      CFG_FRAME_HEIGHT: frame_height = data;
      default: ;
    endcase
  endfunction

  function void record_command(ring_cmd_t c);
    ring_result_t    r;
    int unsigned     n;
    int unsigned     idx;
    bit              found;
    longint unsigned size;
    n = ring_size();
    r.status = ST_DONE;
    r.slot   = '0;
    r.stamp  = '0;
    r.bytes  = '0;
    if (write_ptr >= n) write_ptr = 0;
    if (read_ptr >= n) read_ptr = 0;
    case (c.cmd)
      CMD_WRITE: begin
        idx = write_ptr;
        found = 1'b0;
        for (int k = 0; k < n && !found; k++) begin
          if (!slot_taken[idx]) found = 1'b1;
          else idx = next_slot(idx, n);
        end
        if (!found) begin
          r.status = ST_ALL_TAKEN;
        end else if (!c.copy_ok) begin
          r.status = ST_COPY_FAIL;
        end else begin
          if (!slot_written[idx] && ready_count < n) ready_count++;
          slot_stamp[idx]   = c.stamp;
          slot_written[idx] = 1'b1;
          write_ptr = next_slot(idx, n);
          r.slot = slot_t'(idx);
        end
      end
      CMD_GET: begin
        if (ready_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_NONE_FREE;
          for (int k = 0; k < n && r.status != ST_DONE; k++) begin
            idx = read_ptr;
            read_ptr = next_slot(read_ptr, n);
            if (slot_written[idx] && !slot_taken[idx]) begin
              slot_taken[idx]   = 1'b1;
              slot_written[idx] = 1'b0;
              ready_count--;
              size = longint'(frame_width) * longint'(frame_height) * 3 / 2;
              r.status = ST_DONE;
              r.slot   = slot_t'(idx);
              r.stamp  = slot_stamp[idx];
              r.bytes  = (size > BYTES_MAX) ? BYTES_MAX : bytes_t'(size);
            end
          end
        end
      end
      CMD_RELEASE: begin
        if (c.release_slot >= n) begin
          r.status = ST_BAD_SLOT;
        end else begin
          slot_taken[c.release_slot] = 1'b0;
          r.slot = c.release_slot;
        end
      end
      default: ;
    endcase
    r.count = ready_count[CNT_W-1:0];
    pending_results.push_back(r);
  endfunction

  function void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endfunction

  function void check_result(logic [OUT_W-1:0] beat);
    ring_result_t r;
    if (pending_results.size() == 0) begin
      $error("result beat arrived with no command outstanding");
      error_count++;
      return;
    end
    r = pending_results.pop_front();
    compare_field("status", 64'(r.status), 64'(beat[2:0]));
    compare_field("slot_out", 64'(r.slot), 64'(beat[8:3]));
    compare_field("stamp_out", r.stamp, beat[72:9]);
    compare_field("frame_bytes", 64'(r.bytes), 64'(beat[99:73]));
    compare_field("ready_frames", 64'(r.count), 64'(beat[106:100]));
  endfunction
endclass

module tb_frame_slot_ring_with_checkout_core;
  localparam int RING_SLOTS  = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 185;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [OUT_W-1:0]     m_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  dim_t                 cfg_data;

  slot_ring_scoreboard #(RING_SLOTS) sb;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned cycle_count = 0;

  int unsigned phase_active [PHASES] = '{8, 3, 127, 1, 64, 5, 2, 8};
  int unsigned phase_width  [PHASES] = '{1920, 1, 8192, 16383, 1280, 640, 3, 7};
  int unsigned phase_height [PHASES] = '{1080, 1, 8192, 1, 720, 480, 3, 16383};

  frame_slot_ring_with_checkout_core #(.SLOTS(RING_SLOTS)) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_frame_slot_ring_with_checkout_core failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic issue(cmd_t cmd, stamp_t stamp, logic ok, slot_t rel);
    ring_cmd_t c;
    c.cmd = cmd;
    c.stamp = stamp;
    c.copy_ok = ok;
    c.release_slot = rel;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, rel, ok, stamp, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.record_command(c);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(int unsigned active, int unsigned width, int unsigned height);
    dim_t                 vals [3];
    logic [CFG_IDX_W-1:0] regs [3];
    vals = '{dim_t'(active), dim_t'(width), dim_t'(height)};
    regs = '{CFG_ACTIVE_SLOTS, CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.note_config(regs[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned pick;
    int unsigned n;
    sb = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ACTIVE_SLOTS;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Default ring of eight: empty get, bad and good releases, no-op, failed copy, four writes, a get.
    issue(CMD_GET, '0, 1'b1, 6'd0);
    issue(CMD_RELEASE, '0, 1'b1, 6'd63);
    issue(CMD_RELEASE, '0, 1'b1, 6'd8);
    issue(CMD_RELEASE, '0, 1'b1, 6'd7);
    issue(CMD_NOP, '1, 1'b1, 6'd63);
    issue(CMD_WRITE, 64'h1234, 1'b0, 6'd0);
    issue(CMD_WRITE, '1, 1'b1, 6'd0);
    issue(CMD_WRITE, '0, 1'b1, 6'd0);
    issue(CMD_WRITE, 64'h8000_0000_0000_0001, 1'b1, 6'd0);
    issue(CMD_WRITE, 64'h0123_4567_89ab_cdef, 1'b1, 6'd0);
    issue(CMD_GET, '0, 1'b0, 6'd0);

    // Shrink the ring below the write pointer; the frame size saturates.
    wait_idle();
    configure(2, 16383, 16383);
    issue(CMD_GET, '0, 1'b1, 6'd0);
    issue(CMD_GET, '0, 1'b1, 6'd0);
    issue(CMD_WRITE, 64'hdead_beef, 1'b1, 6'd0);
    issue(CMD_RELEASE, '0, 1'b1, 6'd0);
    issue(CMD_WRITE, 64'hfeed_face, 1'b1, 6'd0);
    issue(CMD_GET, '0, 1'b1, 6'd0);

    // A zero slot count acts as one slot; a zero width gives a zero frame size.
    wait_idle();
    configure(0, 0, 8192);
    issue(CMD_RELEASE, '0, 1'b1, 6'd1);
    issue(CMD_RELEASE, '0, 1'b1, 6'd0);
    issue(CMD_WRITE, 64'h5555_aaaa_5555_aaaa, 1'b1, 6'd0);
    issue(CMD_GET, '0, 1'b1, 6'd0);
    issue(CMD_GET, '0, 1'b1, 6'd0);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      if (p == PHASES - 1) configure(phase_active[p], $urandom_range(1, 16383),
                                     $urandom_range(1, 16383));
      else configure(phase_active[p], phase_width[p], phase_height[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 2 && i == PHASE_ITEMS / 2) wait_idle();
        pick = $urandom_range(0, 99);
        n = sb.ring_size();
        if (pick < 40)
          issue(CMD_WRITE, {$urandom, $urandom}, $urandom_range(0, 9) != 0,
                slot_t'($urandom_range(0, 63)));
        else if (pick < 70)
          issue(CMD_GET, {$urandom, $urandom}, 1'($urandom_range(0, 1)),
                slot_t'($urandom_range(0, 63)));
        else if (pick < 95)
          issue(CMD_RELEASE, {$urandom, $urandom}, 1'($urandom_range(0, 1)),
                slot_t'(($urandom_range(0, 9) < 8) ? $urandom_range(0, n - 1)
                                                   : $urandom_range(0, 63)));
        else
          issue(CMD_NOP, {$urandom, $urandom}, 1'($urandom_range(0, 1)),
                slot_t'($urandom_range(0, 63)));
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.error_count == 0 && sb.pending_results.size() == 0) begin
      $display("tb_frame_slot_ring_with_checkout_core passed");
    end else begin
      $display("tb_frame_slot_ring_with_checkout_core failed");
    end
    $finish;
  end
endmodule
